### hw/rtl/spmv_pkg.sv
`default_nettype none

package spmv_pkg;

	// fixed field widths
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 64;
	localparam int ROW_W   = 16;

	localparam logic [ROW_W-1:0] ROW_COUNT_RST = 16'hFFFF;

	// input item commands; code 3 means nothing and is dropped
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_NONZERO = 2'd1,
		CMD_EMPTY   = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t                      command;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic                      last_in_row;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] row_sum;
		logic [ROW_W-1:0]        row_index;
	} result_t;

	// product stage handed to the accumulator
	typedef struct packed {
		logic                    valid;
		cmd_t                    command;
		logic                    last_in_row;
		logic signed [SUM_W-1:0] product;
	} mac_t;

endpackage

`default_nettype wire

### hw/rtl/spmv_ram.sv
`default_nettype none

module spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/spmv_acc.sv
`default_nettype none

module spmv_acc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spmv_pkg::mac_t                mac,
	input  wire logic [spmv_pkg::ROW_W-1:0]    row_count,
	output logic                               advance,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output spmv_pkg::result_t                  result
);
	import spmv_pkg::*;

	logic signed [SUM_W-1:0] acc_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [SUM_W-1:0] sum;
	logic                    ovf;
	logic signed [SUM_W-1:0] sat_sum;
	logic                    emits;
	logic                    out_free;
	logic [ROW_W:0]          row_next;
	logic [ROW_W-1:0]        row_wrap;

	// saturating add of the product into the row sum
	always_comb begin
		sum = acc_q + mac.product;
		ovf = (acc_q[SUM_W-1] == mac.product[SUM_W-1]) && (sum[SUM_W-1] != acc_q[SUM_W-1]);
		if (!ovf) begin
			sat_sum = sum;
		end else if (acc_q[SUM_W-1]) begin
			sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	// does this item close a row
	always_comb begin
		case (mac.command)
			CMD_NONZERO: emits = mac.last_in_row;
			CMD_EMPTY:   emits = 1'b1;
			default:     emits = 1'b0;
		endcase
	end

	assign out_free = !result_valid || !result_stall;
	assign advance  = mac.valid && (!emits || out_free);

	// row number wraps once it reaches the row count
	assign row_next = {1'b0, row_q} + {{ROW_W{1'b0}}, 1'b1};
	assign row_wrap = (row_next >= {1'b0, row_count}) ? '0 : row_next[ROW_W-1:0];

	// accumulator and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			case (mac.command)
				CMD_NONZERO: begin
					if (mac.last_in_row) begin
						acc_q <= '0;
						row_q <= row_wrap;
					end else begin
						acc_q <= sat_sum;
					end
				end
				CMD_EMPTY: begin
					acc_q <= '0;
					row_q <= row_wrap;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && emits) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emits) begin
			result.row_sum   <= (mac.command == CMD_NONZERO) ? sat_sum : acc_q;
			result.row_index <= row_q;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/csr_sparse_matrix_vector_multiply.sv
`default_nettype none

// Sparse matrix times dense vector, matrix streamed in compressed-row order.
// Input channel (item_valid, item_stall, item): load items fill the vector
// store, nonzero items multiply their value by the stored entry at their
// column and add into a saturating Q32.32 row sum, empty-row items close a row.
// Output channel (result_valid, result_stall, result): one item per closed row
// with the row sum and the row number; row numbers wrap at row_count.
// Config channel (cfg_valid, cfg_ready, cfg_data) writes row_count, always
// ready; write it only while no item is in flight.
// Throughput: one item per cycle while item_stall is low. A row result is
// registered through the vector store read, the multiply and the accumulate
// into the output register after the item that closes the row is accepted.
// A stalled result holds in the output register; the pipeline keeps taking
// items that close no row and stalls the input only once a closing item meets
// a full, stalled output register.
// Reset clears the row sum, row number and pipeline valid bits and sets
// row_count to 65535; vector entries hold nothing until loaded.
module csr_sparse_matrix_vector_multiply #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire spmv_pkg::item_t               item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output spmv_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [spmv_pkg::ROW_W-1:0]    cfg_data
);
	import spmv_pkg::*;

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

	logic                      item_fire;
	logic                      in_range;
	logic [XW-1:0]             index_x;
	logic [AW-1:0]             addr;
	logic [VALUE_W-1:0]        vec_rdata;
	logic [ROW_W-1:0]          row_count_q;

	logic                      valid_s1;
	cmd_t                      command_s1;
	logic                      last_s1;
	logic                      in_range_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic signed [VALUE_W-1:0] vec_s1;
	logic signed [SUM_W-1:0]   product;

	mac_t                      mac_s2;
	logic                      valid_s2;
	cmd_t                      command_s2;
	logic                      last_s2;
	logic signed [SUM_W-1:0]   product_s2;
	logic                      adv_s1;
	logic                      adv_s2;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			row_count_q <= cfg_data;
		end
	end

	// input handshake and stage advance
	assign adv_s1     = valid_s1 && (!valid_s2 || adv_s2);
	assign item_stall = valid_s1 && !adv_s1;
	assign item_fire  = item_valid && !item_stall;

	// vector store addressing
	assign in_range = (32'(item.index) < 32'(VECTOR_DEPTH));
	assign index_x  = XW'(item.index);
	assign addr     = index_x[AW-1:0];

	spmv_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VECTOR_DEPTH)
	) u_vec (
		.clk   (clk),
		.we    (item_fire && (item.command == CMD_LOAD) && in_range),
		.waddr (addr),
		.wdata (item.value),
		.re    (item_fire && (item.command == CMD_NONZERO)),
		.raddr (addr),
		.rdata (vec_rdata)
	);

	// stage 1: item with vector read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			command_s1  <= item.command;
			last_s1     <= item.last_in_row;
			in_range_s1 <= in_range;
			value_s1    <= item.value;
		end
	end

	// out-of-range columns read as zero
	assign vec_s1  = in_range_s1 ? $signed(vec_rdata) : '0;
	assign product = value_s1 * vec_s1;

	// stage 2: registered product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			command_s2 <= command_s1;
			last_s2    <= last_s1;
			product_s2 <= product;
		end
	end

	assign mac_s2 = '{valid_s2, command_s2, last_s2, product_s2};

	// accumulate and emit
	spmv_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.mac          (mac_s2),
		.row_count    (row_count_q),
		.advance      (adv_s2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spmv_pkg::*;

	localparam int VEC_DEPTH = 1024;
	localparam int ROW_LATENCY = 2;
	localparam int SETTLE_CYCLES = ROW_LATENCY + 2;
	localparam int PHASE_ITEMS = 232;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	// one directed item, with its row sum typed in where it is obvious
	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 24;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty row straight after reset, last_in_row ignored
		'{'{CMD_EMPTY,   10'd0,    32'sh0000_0000, 1'b1}, 1'b1, '{64'sd0, 16'd0}},
		'{'{CMD_LOAD,    10'd0,    32'sh7FFF_FFFF, 1'b0}, 1'b0, '0},
		'{'{CMD_LOAD,    10'd1023, 32'sh8000_0000, 1'b1}, 1'b0, '0},
		'{'{CMD_LOAD,    10'd1,    32'sh0001_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_LOAD,    10'd2,    32'shFFFF_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd1,    32'sh0002_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd2,    32'sh0003_0000, 1'b1}, 1'b0, '0},
		// unused command code, dropped
		'{'{cmd_t'(CMD_UNUSED), 10'd1023, 32'sh1234_5678, 1'b1}, 1'b0, '0},
		// two largest products overflow upwards
		'{'{CMD_NONZERO, 10'd1023, 32'sh8000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd1023, 32'sh8000_0000, 1'b1}, 1'b1, '{SUM_MAX, 16'd2}},
		// three large negative products overflow downwards
		'{'{CMD_NONZERO, 10'd0,    32'sh8000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd0,    32'sh8000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd0,    32'sh8000_0000, 1'b1}, 1'b1, '{SUM_MIN, 16'd3}},
		'{'{CMD_NONZERO, 10'd0,    32'sh7FFF_FFFF, 1'b1}, 1'b0, '0},
		// empty row closes a row with a pending nonzero
		'{'{CMD_NONZERO, 10'd1,    32'sh0001_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_EMPTY,   10'd0,    32'sh0000_0000, 1'b0}, 1'b1, '{64'sh1_0000_0000, 16'd5}},
		'{'{CMD_EMPTY,   10'd1023, 32'shFFFF_FFFF, 1'b0}, 1'b1, '{64'sd0, 16'd6}},
		'{'{CMD_LOAD,    10'd512,  32'sh0000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd512,  32'sh7FFF_FFFF, 1'b1}, 1'b1, '{64'sd0, 16'd7}},
		// overwrite followed at once by a read of the same entry
		'{'{CMD_LOAD,    10'd1,    32'sh0000_8000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd1,    32'shFFFF_8000, 1'b1}, 1'b0, '0},
		// saturated sum pulled back by a later product
		'{'{CMD_NONZERO, 10'd1023, 32'sh8000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd1023, 32'sh8000_0000, 1'b0}, 1'b0, '0},
		'{'{CMD_NONZERO, 10'd2,    32'sh0001_0000, 1'b1}, 1'b0, '0}
	};

	logic             clk;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [ROW_W-1:0] cfg_data = '0;

	// predicted block state
	logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
	bit                        vec_loaded [VEC_DEPTH];
	logic [INDEX_W-1:0]        loaded_idx [$];
	logic signed [SUM_W-1:0]   acc_model = '0;
	logic [ROW_W-1:0]          row_model = '0;
	logic [ROW_W-1:0]          row_count_model = ROW_COUNT_RST;
	result_t                   row_sums_due [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int failures = 0;
	int items_sent = 0;
	int rows_checked = 0;
	int saturated_rows = 0;
	int rows_at_zero = 0;

	csr_sparse_matrix_vector_multiply #(
		.VECTOR_DEPTH(VEC_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// advance the predicted state by one accepted item, return 1 when a row closes
	function automatic bit predict_row_sum(input item_t it, output result_t closed);
		logic signed [SUM_W-1:0] prod;
		logic [SUM_W:0]          wide;
		logic [ROW_W:0]          next_row;
		bit                      closes;
		logic signed [VALUE_W-1:0] vec;
		closes = 1'b0;
		closed = '0;
		case (it.command)
			CMD_LOAD: begin
				vec_mem[it.index] = it.value;
				if (!vec_loaded[it.index]) begin
					vec_loaded[it.index] = 1'b1;
					loaded_idx.push_back(it.index);
				end
			end
			CMD_NONZERO: begin
				vec = vec_mem[it.index];
				prod = $signed({{32{it.value[31]}}, it.value}) * $signed({{32{vec[31]}}, vec});
				wide = {acc_model[SUM_W-1], acc_model} + {prod[SUM_W-1], prod};
				// saturate when the carry out disagrees with the sign
				if (wide[SUM_W] != wide[SUM_W-1])
					acc_model = wide[SUM_W] ? SUM_MIN : SUM_MAX;
				else
					acc_model = wide[SUM_W-1:0];
				closes = it.last_in_row;
			end
			CMD_EMPTY: closes = 1'b1;
			default: ;
		endcase
		if (closes) begin
			closed.row_sum = acc_model;
			closed.row_index = row_model;
			acc_model = '0;
			next_row = {1'b0, row_model} + 1'b1;
			row_model = (next_row >= {1'b0, row_count_model}) ? '0 : next_row[ROW_W-1:0];
		end
		return closes;
	endfunction

	// mostly small Q16.16 values, some extremes, some anything
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
		endcase
	endfunction

	// nonzero on a column that has been loaded
	function automatic item_t nonzero_item(input bit last);
		item_t it;
		it.command = CMD_NONZERO;
		it.index = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
		it.value = pick_value();
		it.last_in_row = last;
		return it;
	endfunction

	// drive one item, hold it until accepted, then predict its row sum
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		result_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		if (predict_row_sum(it, r))
			row_sums_due.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic write_row_count(input logic [ROW_W-1:0] rows);
		cfg_valid <= 1'b1;
		cfg_data <= rows;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		row_count_model = rows;
	endtask

	// stop sending until every row sum is out, then let the pipe settle
	task automatic drain_rows(input int settle);
		item_valid <= 1'b0;
		while (row_sums_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_random(input int quota);
		int    counted;
		int    pick;
		int    n;
		bit    paused;
		item_t it;
		counted = 0;
		paused = 1'b0;
		while (counted < quota) begin
			// one mid-phase pause until all rows are out
			if (!paused && counted >= quota / 2) begin
				drain_rows(1);
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 12 || loaded_idx.size() < 4) begin
				// burst of vector loads
				n = $urandom_range(1, 6);
				repeat (n) begin
					it = '{CMD_LOAD, INDEX_W'($urandom_range(0, VEC_DEPTH - 1)),
						pick_value(), 1'($urandom_range(0, 1))};
					send_item(it, 1'b0, '0);
					counted++;
				end
			end else if (pick < 80) begin
				// well-formed row, possibly empty
				n = $urandom_range(0, 6);
				if (n == 0) begin
					it = '{CMD_EMPTY, INDEX_W'($urandom), pick_value(), 1'($urandom_range(0, 1))};
					send_item(it, 1'b0, '0);
					counted++;
				end else begin
					for (int k = 1; k <= n; k++) begin
						send_item(nonzero_item(k == n), 1'b0, '0);
						counted++;
					end
				end
			end else if (pick < 88) begin
				// unused command, ignored by the block
				it = '{cmd_t'(CMD_UNUSED), INDEX_W'($urandom), $urandom, 1'($urandom_range(0, 1))};
				send_item(it, 1'b0, '0);
				counted++;
			end else begin
				// broken row closed by an empty-row item
				n = $urandom_range(1, 3);
				repeat (n) begin
					send_item(nonzero_item(1'b0), 1'b0, '0);
					counted++;
				end
				it = '{CMD_EMPTY, INDEX_W'($urandom), pick_value(), 1'($urandom_range(0, 1))};
				send_item(it, 1'b0, '0);
				counted++;
			end
		end
	endtask

	// result side: random stall, check every accepted row sum in order
	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (row_sums_due.size() == 0) begin
					$error("row sum %0h for row %0d with none expected", result.row_sum,
						result.row_index);
					failures++;
				end else begin
					want = row_sums_due.pop_front();
					if (result.row_sum !== want.row_sum) begin
						$error("row_sum: expected %0h, got %0h", want.row_sum, result.row_sum);
						failures++;
					end
					if (result.row_index !== want.row_index) begin
						$error("row_index: expected %0d, got %0d", want.row_index,
							result.row_index);
						failures++;
					end
					if (want.row_sum == SUM_MAX || want.row_sum == SUM_MIN)
						saturated_rows++;
					if (want.row_index == '0)
						rows_at_zero++;
					rows_checked++;
				end
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// stimulus
	initial begin
		logic [ROW_W-1:0] rows;
		logic [ROW_W-1:0] last_rows;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items with the reset row count
		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		drain_rows(SETTLE_CYCLES);

		// random phases, each with its own row count and idling pattern
		last_rows = '0;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; rows = 16'd1; end
				1: begin idle_pct = 84; stall_pct = 0; rows = 16'd7; end
				2: begin idle_pct = 0; stall_pct = 84; rows = ROW_COUNT_RST; end
				default: begin
					idle_pct = 15;
					stall_pct = 15;
					rows = ROW_W'($urandom_range(2, 20));
					last_rows = rows;
				end
			endcase
			write_row_count(rows);
			run_random(PHASE_ITEMS);
			drain_rows(SETTLE_CYCLES);
		end

		if (row_sums_due.size() != 0) begin
			$error("%0d row sums never arrived", row_sums_due.size());
			failures++;
		end

		$display("covered %0d items and %0d row sums, %0d saturated, %0d on row zero",
			items_sent, rows_checked, saturated_rows, rows_at_zero);
		$display("row counts used: 65535, 1, 7, 65535 and %0d", last_rows);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
